[rtl/pawl_disengage_sequencer_macros.svh]
// Assertion macros for the pawl disengage sequencer.
`ifndef PAWL_DISENGAGE_SEQUENCER_MACROS_SVH
`define PAWL_DISENGAGE_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
`define PDS_CHECK(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pds check failed");
`define PDS_CHECK_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pds next-cycle check failed");
`else
`define PDS_CHECK(name, clk, rst_n, ante, cons)
`define PDS_CHECK_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

[rtl/pds_pkg.sv]
// Shared types, constants and command builders for the pawl disengage sequencer.
package pds_pkg;

    localparam int MaxResults   = 6;
    localparam int QueueDepthDefault = 2;
    localparam int CfgIdxW      = 3;
    localparam int CfgDataW     = 16;
    localparam int CntW         = $clog2(MaxResults + 1);

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_RIGHT_LIMIT = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_LEFT_LIMIT  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_CAM_UPPER   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_CAM_LOWER   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_CAM_MIDDLE  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_MAX_TRIES   = 3'd5;

    localparam logic [15:0]        RST_RIGHT_LIMIT = 16'd512;
    localparam logic [15:0]        RST_LEFT_LIMIT  = 16'd512;
    localparam logic signed [15:0] RST_CAM_UPPER   = 16'sd100;
    localparam logic signed [15:0] RST_CAM_LOWER   = -16'sd100;
    localparam logic signed [15:0] RST_CAM_MIDDLE  = 16'sd0;
    localparam logic [7:0]         RST_MAX_TRIES   = 8'd10;

    // input opcodes and modes
    localparam logic OP_START = 1'b0;
    localparam logic OP_POLL  = 1'b1;
    localparam logic [1:0] MODE_LEFT  = 2'd0;
    localparam logic [1:0] MODE_RIGHT = 2'd1;
    localparam logic [1:0] MODE_REST  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_DONE  = 2'd3
    } t_cmd_code;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FIRST_READ = 2'd1,
        ST_MOTOR      = 2'd2,
        ST_READ       = 2'd3
    } t_status;

    localparam logic [1:0] SPD_MEDIUM = 2'd0;
    localparam logic [1:0] SPD_SLOW   = 2'd1;

    localparam logic [9:0] RT_LONG    = 10'd1000;
    localparam logic [9:0] RT_RESTART = 10'd100;
    localparam logic [9:0] RT_BACKOFF = 10'd75;
    localparam logic [2:0] STEP_COUNT = 3'd5;

    typedef struct packed {
        logic              opcode;
        logic [1:0]        mode;
        logic              read_ok;
        logic [15:0]       left_reading;
        logic signed [15:0] cam_reading;
        logic [15:0]       right_reading;
        logic              motor_running;
    } t_in_item;

    typedef struct packed {
        t_cmd_code   command;
        logic        gear_direction;
        logic [1:0]  speed_code;
        logic [9:0]  run_time;
        logic        main_direction;
        logic [2:0]  main_steps;
        t_status     status;
    } t_cmd;

    typedef struct packed {
        t_cmd_code   command;
        logic        gear_direction;
        logic [1:0]  speed_code;
        logic [9:0]  run_time;
        logic        main_direction;
        logic [2:0]  main_steps;
        t_status     status;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [CntW-1:0]             cnt;
        t_cmd [MaxResults-1:0]       slots;
    } t_burst;

    function automatic t_cmd mk_start(logic dir, logic [1:0] spd, logic [9:0] rt);
        t_cmd c;
        c = '0;
        c.command        = CMD_START;
        c.gear_direction = dir;
        c.speed_code     = spd;
        c.run_time       = rt;
        return c;
    endfunction

    function automatic t_cmd mk_stop();
        t_cmd c;
        c = '0;
        c.command = CMD_STOP;
        return c;
    endfunction

    function automatic t_cmd mk_step(logic mdir);
        t_cmd c;
        c = '0;
        c.command        = CMD_STEP;
        c.main_direction = mdir;
        c.main_steps     = STEP_COUNT;
        return c;
    endfunction

    function automatic t_cmd mk_done(t_status st);
        t_cmd c;
        c = '0;
        c.command = CMD_DONE;
        c.status  = st;
        return c;
    endfunction

endpackage

[rtl/pds_if.sv]
// Valid/ready channel interfaces for sensor items and motor commands.
interface pds_in_if;
    logic              valid;
    logic              ready;
    pds_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pds_out_if;
    logic               valid;
    logic               ready;
    pds_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/pds_queue.sv]
// Small register FIFO between the classifying front and the command back end.
`include "pawl_disengage_sequencer_macros.svh"
module pds_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_rdata,
    input  logic             i_pop
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == FullCnt);
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LastPtr) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LastPtr) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `PDS_CHECK(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `PDS_CHECK(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_valid)
endmodule

[rtl/pds_front.sv]
// Front end: config registers, sequence state and per-item command bursts.
module pds_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pds_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [pds_pkg::CfgDataW-1:0]   i_cfg_wdata,
    pds_in_if.sink                         i_in_ch,
    input  logic                           i_q_full,
    output logic                           o_push,
    output pds_pkg::t_burst                o_burst
);
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PAWL = 2'd1,
        PH_CAM  = 2'd2
    } t_phase;

    logic [15:0]        r_right_limit, r_left_limit;
    logic signed [15:0] r_cam_upper, r_cam_lower, r_cam_middle;
    logic [7:0]         r_max_tries;

    t_phase             r_phase, n_phase;
    logic               r_right, n_right;
    logic [7:0]         r_motor, n_motor;
    logic [7:0]         r_read, n_read;
    logic               r_dir, n_dir;
    logic [1:0]         r_speed, n_speed;
    logic signed [15:0] r_last, n_last;

    pds_pkg::t_in_item             it;
    logic                          fire;
    logic                          failed;
    logic                          pick_left;
    logic [15:0]                   pawl_val, pawl_lim;
    logic                          in_window;
    logic [pds_pkg::CntW-1:0]      cnt;
    pds_pkg::t_cmd [pds_pkg::MaxResults-1:0] slots;

    assign it            = i_in_ch.data;
    assign i_in_ch.ready = !i_q_full;
    assign fire          = i_in_ch.valid && !i_q_full;
    assign in_window     = (it.cam_reading <= r_cam_upper) && (it.cam_reading >= r_cam_lower);

    always_comb begin
        n_phase  = r_phase;
        n_right  = r_right;
        n_motor  = r_motor;
        n_read   = r_read;
        n_dir    = r_dir;
        n_speed  = r_speed;
        n_last   = r_last;
        cnt      = '0;
        slots    = '0;
        failed   = 1'b0;
        pick_left = (it.opcode == pds_pkg::OP_START) ? (it.mode == pds_pkg::MODE_LEFT) : !r_right;
        pawl_val = pick_left ? it.left_reading : it.right_reading;
        pawl_lim = pick_left ? r_left_limit : r_right_limit;

        if (it.opcode == pds_pkg::OP_START) begin
            n_phase = PH_IDLE;
            n_motor = '0;
            n_read  = '0;
            n_speed = '0;
            if (it.mode == pds_pkg::MODE_NONE) begin
                slots[cnt] = pds_pkg::mk_done(pds_pkg::ST_OK);
                cnt = cnt + 1'b1;
            end else if (!it.read_ok) begin
                slots[cnt] = pds_pkg::mk_done(pds_pkg::ST_FIRST_READ);
                cnt = cnt + 1'b1;
            end else if (it.mode == pds_pkg::MODE_REST) begin
                n_last = it.cam_reading;
                if (in_window) begin
                    slots[cnt] = pds_pkg::mk_done(pds_pkg::ST_OK);
                    cnt = cnt + 1'b1;
                end else begin
                    n_dir = !(it.cam_reading > r_cam_middle);
                    slots[cnt] = pds_pkg::mk_start(n_dir, pds_pkg::SPD_SLOW, pds_pkg::RT_LONG);
                    cnt = cnt + 1'b1;
                    n_phase = PH_CAM;
                end
            end else begin
                n_right = (it.mode == pds_pkg::MODE_RIGHT);
                if (pawl_val <= pawl_lim) begin
                    slots[cnt] = pds_pkg::mk_done(pds_pkg::ST_OK);
                    cnt = cnt + 1'b1;
                end else begin
                    n_dir = (it.mode == pds_pkg::MODE_RIGHT);
                    slots[cnt] = pds_pkg::mk_start(n_dir, pds_pkg::SPD_MEDIUM,
                                                   pds_pkg::RT_LONG);
                    cnt = cnt + 1'b1;
                    n_phase = PH_PAWL;
                end
            end
        end else if (r_phase == PH_PAWL) begin
            if (r_read == '0 && !it.motor_running) begin
                if (r_motor >= r_max_tries) begin
                    slots[cnt] = pds_pkg::mk_done(pds_pkg::ST_MOTOR);
                    cnt = cnt + 1'b1;
                    n_phase = PH_IDLE;
                    failed = 1'b1;
                end else begin
                    n_motor = r_motor + 1'b1;
                    slots[cnt] = pds_pkg::mk_step(pick_left);
                    cnt = cnt + 1'b1;
                    slots[cnt] = pds_pkg::mk_start(r_dir, pds_pkg::SPD_MEDIUM,
                                                   pds_pkg::RT_RESTART);
                    cnt = cnt + 1'b1;
                end
            end
            if (!failed) begin
                if (r_read >= r_max_tries) begin
                    slots[cnt] = pds_pkg::mk_done(pds_pkg::ST_READ);
                    cnt = cnt + 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_read = r_read + 1'b1;
                    if (it.read_ok) begin
                        n_read = '0;
                        if (pawl_val <= pawl_lim) begin
                            slots[cnt] = pds_pkg::mk_stop();
                            cnt = cnt + 1'b1;
                            slots[cnt] = pds_pkg::mk_done(pds_pkg::ST_OK);
                            cnt = cnt + 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                end
            end
        end else if (r_phase == PH_CAM) begin
            if (r_read == '0) begin
                if (!it.motor_running) begin
                    if (r_motor >= r_max_tries) begin
                        slots[cnt] = pds_pkg::mk_done(pds_pkg::ST_MOTOR);
                        cnt = cnt + 1'b1;
                        n_phase = PH_IDLE;
                        failed = 1'b1;
                    end else begin
                        n_motor = r_motor + 1'b1;
                        slots[cnt] = pds_pkg::mk_start(r_dir, pds_pkg::SPD_SLOW,
                                                       pds_pkg::RT_LONG);
                        cnt = cnt + 1'b1;
                    end
                end
                if (!failed && ((r_last > r_cam_middle && r_dir) ||
                                (r_last < r_cam_middle && !r_dir))) begin
                    slots[cnt] = pds_pkg::mk_stop();
                    cnt = cnt + 1'b1;
                    n_dir = !r_dir;
                    n_speed = (r_speed == 2'd2) ? 2'd0 : r_speed + 2'd1;
                    slots[cnt] = pds_pkg::mk_start(n_dir, n_speed + 2'd1, pds_pkg::RT_LONG);
                    cnt = cnt + 1'b1;
                end
            end
            if (!failed) begin
                if (r_read >= r_max_tries) begin
                    slots[cnt] = pds_pkg::mk_done(pds_pkg::ST_READ);
                    cnt = cnt + 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_read = r_read + 1'b1;
                    if (it.read_ok) begin
                        n_read = '0;
                        n_last = it.cam_reading;
                        if (in_window) begin
                            slots[cnt] = pds_pkg::mk_stop();
                            cnt = cnt + 1'b1;
                            n_dir = !n_dir;
                            slots[cnt] = pds_pkg::mk_start(n_dir, pds_pkg::SPD_SLOW,
                                                           pds_pkg::RT_BACKOFF);
                            cnt = cnt + 1'b1;
                            slots[cnt] = pds_pkg::mk_done(pds_pkg::ST_OK);
                            cnt = cnt + 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                end
            end
        end
    end

    assign o_push        = fire && (cnt != '0);
    assign o_burst.cnt   = cnt;
    assign o_burst.slots = slots;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right_limit <= pds_pkg::RST_RIGHT_LIMIT;
            r_left_limit  <= pds_pkg::RST_LEFT_LIMIT;
            r_cam_upper   <= pds_pkg::RST_CAM_UPPER;
            r_cam_lower   <= pds_pkg::RST_CAM_LOWER;
            r_cam_middle  <= pds_pkg::RST_CAM_MIDDLE;
            r_max_tries   <= pds_pkg::RST_MAX_TRIES;
            r_phase       <= PH_IDLE;
            r_right       <= 1'b0;
            r_motor       <= '0;
            r_read        <= '0;
            r_dir         <= 1'b0;
            r_speed       <= '0;
            r_last        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pds_pkg::CFG_RIGHT_LIMIT: r_right_limit <= i_cfg_wdata;
                    pds_pkg::CFG_LEFT_LIMIT:  r_left_limit  <= i_cfg_wdata;
                    pds_pkg::CFG_CAM_UPPER:   r_cam_upper   <= i_cfg_wdata;
                    pds_pkg::CFG_CAM_LOWER:   r_cam_lower   <= i_cfg_wdata;
                    pds_pkg::CFG_CAM_MIDDLE:  r_cam_middle  <= i_cfg_wdata;
                    pds_pkg::CFG_MAX_TRIES:   r_max_tries   <= i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (fire) begin
                r_phase <= n_phase;
                r_right <= n_right;
                r_motor <= n_motor;
                r_read  <= n_read;
                r_dir   <= n_dir;
                r_speed <= n_speed;
                r_last  <= n_last;
            end
        end
    end
endmodule

[rtl/pds_back.sv]
// Back end: plays out each queued command burst one command per transfer, flagging the last.
`include "pawl_disengage_sequencer_macros.svh"
module pds_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  pds_pkg::t_burst i_q_data,
    output logic            o_q_pop,
    pds_out_if.source       o_out_ch
);
    localparam int IdxW = $clog2(pds_pkg::MaxResults);
    localparam int CntW = pds_pkg::CntW;

    pds_pkg::t_burst r_burst;
    logic            r_busy;
    logic [IdxW-1:0] r_idx;

    pds_pkg::t_cmd   cur;
    logic            is_last;
    logic            out_fire;

    assign cur      = r_burst.slots[r_idx];
    assign is_last  = (CntW'(r_idx) == r_burst.cnt - 1'b1);
    assign out_fire = o_out_ch.valid && o_out_ch.ready;
    assign o_q_pop  = i_q_valid && (!r_busy || (out_fire && is_last));

    assign o_out_ch.valid               = r_busy;
    assign o_out_ch.data.command        = cur.command;
    assign o_out_ch.data.gear_direction = cur.gear_direction;
    assign o_out_ch.data.speed_code     = cur.speed_code;
    assign o_out_ch.data.run_time       = cur.run_time;
    assign o_out_ch.data.main_direction = cur.main_direction;
    assign o_out_ch.data.main_steps     = cur.main_steps;
    assign o_out_ch.data.status         = cur.status;
    assign o_out_ch.data.last           = is_last;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_burst <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_q_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (out_fire) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    `PDS_CHECK(a_idx_in_burst, i_clk, i_rst_n, r_busy, CntW'(r_idx) < r_burst.cnt)
    `PDS_CHECK_NEXT(a_drain_idle, i_clk, i_rst_n, out_fire && is_last && !i_q_valid, !r_busy)
endmodule

[rtl/pawl_disengage_sequencer.sv]
// Pawl disengage sequencer: sensor items in, gear/main motor commands out.
//
// i_in_ch carries start and poll items; o_out_ch carries commands, one per
// transfer, with last set on the final command an item causes. Items that
// cause no command (a poll while idle) are taken and vanish.
// The front decides an item's whole command burst in the cycle it is taken
// and pushes it into a burst queue (QueueDepth entries); the back end plays
// a burst out one command per cycle while o_out_ch.ready is high.
// The first command of a burst becomes valid once the burst has been written
// into the queue and then loaded into the back end's burst register.
// Throughput: one item per cycle into the queue while it is not full; the
// back end's single output port plays a queued item's commands (1 to 6) out
// one at a time. i_in_ch.ready drops only while the queue is full.
// When o_out_ch.ready is low the current command holds and the queue fills.
// Reset (i_rst_n low at a clock edge) loads register defaults, empties the
// queue and returns the sequence to idle. Config writes via i_cfg_we,
// i_cfg_idx, i_cfg_wdata take effect at the next edge.
module pawl_disengage_sequencer #(
    parameter int QueueDepth = pds_pkg::QueueDepthDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pds_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [pds_pkg::CfgDataW-1:0] i_cfg_wdata,
    pds_in_if.sink                       i_in_ch,
    pds_out_if.source                    o_out_ch
);
    localparam int BurstW = $bits(pds_pkg::t_burst);

    logic            q_push, q_full, q_valid, q_pop;
    pds_pkg::t_burst push_burst, head_burst;
    logic [BurstW-1:0] head_bits;

    pds_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_ch     (i_in_ch),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_burst     (push_burst)
    );

    pds_queue #(
        .WIDTH (BurstW),
        .DEPTH (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (push_burst),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rdata (head_bits),
        .i_pop   (q_pop)
    );

    assign head_burst = head_bits;

    pds_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (head_burst),
        .o_q_pop   (q_pop),
        .o_out_ch  (o_out_ch)
    );
endmodule

[test/testbench.sv]
// Self-checking testbench for the pawl disengage sequencer.
`timescale 1ns / 1ps

module testbench;
    import pds_pkg::*;

    localparam int CycleLimit = 500000;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_PAWL = 2'd1,
        SEQ_CAM  = 2'd2
    } t_seq_phase;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CfgIdxW-1:0]   i_cfg_idx;
    logic [CfgDataW-1:0]  i_cfg_wdata;

    pds_in_if  in_ch();
    pds_out_if out_ch();

    pawl_disengage_sequencer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch)
    );

    always #10 i_clk = ~i_clk;

    // sequencer model state and register copies
    t_seq_phase         seq_ph;
    logic [1:0]         act_mode;
    logic [7:0]         motor_tries;
    logic [7:0]         read_tries;
    logic               drive_dir;
    logic [1:0]         spd_idx;
    logic signed [15:0] cam_last;
    logic [15:0]        lim_right;
    logic [15:0]        lim_left;
    logic signed [15:0] cam_hi;
    logic signed [15:0] cam_lo;
    logic signed [15:0] cam_mid;
    logic [7:0]         tries_max;

    t_out_item burst[$];
    t_out_item due_cmds[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int items_taken    = 0;
    int n_fail         = 0;
    int cycle_cnt      = 0;

    t_out_item want;
    t_out_item got;

    function automatic void reset_model();
        seq_ph      = SEQ_IDLE;
        act_mode    = MODE_LEFT;
        motor_tries = '0;
        read_tries  = '0;
        drive_dir   = 1'b0;
        spd_idx     = '0;
        cam_last    = '0;
        lim_right   = RST_RIGHT_LIMIT;
        lim_left    = RST_LEFT_LIMIT;
        cam_hi      = RST_CAM_UPPER;
        cam_lo      = RST_CAM_LOWER;
        cam_mid     = RST_CAM_MIDDLE;
        tries_max   = RST_MAX_TRIES;
    endfunction

    function automatic void add_cmd(input t_cmd_code code, input logic gdir,
                                    input logic [1:0] spd, input logic [9:0] rt,
                                    input logic mdir, input logic [2:0] steps,
                                    input t_status st);
        t_out_item c;
        c.command        = code;
        c.gear_direction = gdir;
        c.speed_code     = spd;
        c.run_time       = rt;
        c.main_direction = mdir;
        c.main_steps     = steps;
        c.status         = st;
        c.last           = 1'b0;
        burst.push_back(c);
    endfunction

    function automatic void end_seq(input t_status st);
        seq_ph = SEQ_IDLE;
        add_cmd(CMD_DONE, 1'b0, '0, '0, 1'b0, '0, st);
    endfunction

    function automatic bit cam_centered(input logic signed [15:0] c);
        return c <= cam_hi && c >= cam_lo;
    endfunction

    // Advances the model by one accepted item and queues the commands it causes.
    // Returns 1 when the item is a poll that the idle sequencer drops.
    function automatic bit predict_cmds(input t_in_item it);
        logic signed [15:0] cam;
        logic [15:0]        rd;
        logic [15:0]        lim;
        bit                 failed;
        bit                 is_left;
        t_out_item          tail;
        cam    = it.cam_reading;
        failed = 1'b0;
        burst.delete();
        if (it.opcode == OP_POLL && seq_ph == SEQ_IDLE) return 1'b1;
        if (it.opcode == OP_START) begin
            seq_ph      = SEQ_IDLE;
            motor_tries = '0;
            read_tries  = '0;
            spd_idx     = '0;
            if (it.mode == MODE_NONE) begin
                end_seq(ST_OK);
            end else if (!it.read_ok) begin
                end_seq(ST_FIRST_READ);
            end else if (it.mode == MODE_REST) begin
                cam_last = cam;
                if (cam_centered(cam)) begin
                    end_seq(ST_OK);
                end else begin
                    drive_dir = !(cam > cam_mid);
                    add_cmd(CMD_START, drive_dir, SPD_SLOW, RT_LONG, 1'b0, '0, ST_OK);
                    seq_ph = SEQ_CAM;
                end
            end else begin
                act_mode = it.mode;
                is_left  = (it.mode == MODE_LEFT);
                rd  = is_left ? it.left_reading : it.right_reading;
                lim = is_left ? lim_left : lim_right;
                if (rd <= lim) begin
                    end_seq(ST_OK);
                end else begin
                    drive_dir = !is_left;
                    add_cmd(CMD_START, drive_dir, SPD_MEDIUM, RT_LONG, 1'b0, '0, ST_OK);
                    seq_ph = SEQ_PAWL;
                end
            end
        end else begin
            is_left = (act_mode == MODE_LEFT);
            // motor check only when no read retry is pending
            if (read_tries == 0 && !it.motor_running) begin
                if (motor_tries >= tries_max) begin
                    end_seq(ST_MOTOR);
                    failed = 1'b1;
                end else begin
                    motor_tries++;
                    if (seq_ph == SEQ_PAWL) begin
                        add_cmd(CMD_STEP, 1'b0, '0, '0, is_left, STEP_COUNT, ST_OK);
                        add_cmd(CMD_START, drive_dir, SPD_MEDIUM, RT_RESTART, 1'b0, '0, ST_OK);
                    end else begin
                        add_cmd(CMD_START, drive_dir, SPD_SLOW, RT_LONG, 1'b0, '0, ST_OK);
                    end
                end
            end
            // cam passed the middle: reverse and cycle the slow speeds
            if (!failed && seq_ph == SEQ_CAM && read_tries == 0 &&
                ((cam_last > cam_mid && drive_dir) || (cam_last < cam_mid && !drive_dir))) begin
                add_cmd(CMD_STOP, 1'b0, '0, '0, 1'b0, '0, ST_OK);
                drive_dir = !drive_dir;
                spd_idx   = (spd_idx == 2'd2) ? 2'd0 : spd_idx + 2'd1;
                add_cmd(CMD_START, drive_dir, spd_idx + 2'd1, RT_LONG, 1'b0, '0, ST_OK);
            end
            if (!failed) begin
                if (read_tries >= tries_max) begin
                    end_seq(ST_READ);
                end else begin
                    read_tries++;
                    if (it.read_ok) begin
                        read_tries = '0;
                        if (seq_ph == SEQ_PAWL) begin
                            rd  = is_left ? it.left_reading : it.right_reading;
                            lim = is_left ? lim_left : lim_right;
                            if (rd <= lim) begin
                                add_cmd(CMD_STOP, 1'b0, '0, '0, 1'b0, '0, ST_OK);
                                end_seq(ST_OK);
                            end
                        end else begin
                            cam_last = cam;
                            if (cam_centered(cam)) begin
                                add_cmd(CMD_STOP, 1'b0, '0, '0, 1'b0, '0, ST_OK);
                                drive_dir = !drive_dir;
                                add_cmd(CMD_START, drive_dir, SPD_SLOW, RT_BACKOFF, 1'b0, '0,
                                        ST_OK);
                                end_seq(ST_OK);
                            end
                        end
                    end
                end
            end
        end
        if (burst.size() > 0) begin
            tail = burst.pop_back();
            tail.last = 1'b1;
            burst.push_back(tail);
            foreach (burst[k]) due_cmds.push_back(burst[k]);
        end
        return 1'b0;
    endfunction

    function automatic void check_field(input string what, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, actual %0d", what, exp_v, act_v);
            n_fail++;
        end
    endfunction

    // command sink: random stalls and in-order comparison
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (due_cmds.size() == 0) begin
                $error("command %0d transferred with nothing pending", got.command);
                n_fail++;
            end else begin
                want = due_cmds.pop_front();
                check_field("command", want.command, got.command);
                check_field("gear_direction", want.gear_direction, got.gear_direction);
                check_field("speed_code", want.speed_code, got.speed_code);
                check_field("run_time", want.run_time, got.run_time);
                check_field("main_direction", want.main_direction, got.main_direction);
                check_field("main_steps", want.main_steps, got.main_steps);
                check_field("status", want.status, got.status);
                check_field("last", want.last, got.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_RIGHT_LIMIT: lim_right = val;
            CFG_LEFT_LIMIT:  lim_left  = val;
            CFG_CAM_UPPER:   cam_hi    = val;
            CFG_CAM_LOWER:   cam_lo    = val;
            CFG_CAM_MIDDLE:  cam_mid   = val;
            CFG_MAX_TRIES:   tries_max = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] r_lim, input logic [15:0] l_lim,
                              input logic signed [15:0] c_hi, input logic signed [15:0] c_lo,
                              input logic signed [15:0] c_mid, input logic [7:0] tries);
        write_reg(CFG_RIGHT_LIMIT, r_lim);
        write_reg(CFG_LEFT_LIMIT, l_lim);
        write_reg(CFG_CAM_UPPER, c_hi);
        write_reg(CFG_CAM_LOWER, c_lo);
        write_reg(CFG_CAM_MIDDLE, c_mid);
        write_reg(CFG_MAX_TRIES, {8'd0, tries});
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        if (!predict_cmds(it)) items_taken++;
    endtask

    // holds off the sender until every pending command has been transferred
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (due_cmds.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_in_item sensor_item(input logic op, input logic [1:0] mode,
                                             input logic ok, input logic [15:0] left,
                                             input logic signed [15:0] cam,
                                             input logic [15:0] right, input logic run);
        t_in_item it;
        it.opcode        = op;
        it.mode          = mode;
        it.read_ok       = ok;
        it.left_reading  = left;
        it.cam_reading   = cam;
        it.right_reading = right;
        it.motor_running = run;
        return it;
    endfunction

    function automatic t_in_item random_item();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(t_in_item)-1:0];
    endfunction

    function automatic logic [15:0] pick_pawl(input logic [15:0] lim, input int release_pct);
        if ($urandom_range(99) < release_pct || lim == 16'hFFFF)
            return 16'($urandom_range(int'(lim)));
        return 16'($urandom_range(65535, int'(lim) + 1));
    endfunction

    function automatic logic signed [15:0] pick_cam();
        int v;
        case ($urandom_range(3))
            0: v = int'($urandom_range(65535)) - 32768;
            1: v = int'(cam_mid) + int'($urandom_range(600)) - 300;
            2: begin
                if (cam_lo <= cam_hi)
                    v = int'(cam_lo) + int'($urandom_range(int'(cam_hi) - int'(cam_lo)));
                else
                    v = int'(cam_mid);
            end
            default: begin
                if ($urandom_range(1))
                    v = int'(cam_hi) + 1 + int'($urandom_range(400));
                else
                    v = int'(cam_lo) - 1 - int'($urandom_range(400));
            end
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // a start followed by polls until the sequence ends or is cut short
    task automatic random_sequence();
        t_in_item it;
        int       polls;
        int       pick;
        it = random_item();
        it.opcode = OP_START;
        pick = $urandom_range(19);
        it.mode = (pick < 8) ? MODE_LEFT : (pick < 14) ? MODE_RIGHT :
                  (pick < 19) ? MODE_REST : MODE_NONE;
        it.read_ok       = ($urandom_range(19) != 0);
        it.left_reading  = pick_pawl(lim_left, 15);
        it.right_reading = pick_pawl(lim_right, 15);
        it.cam_reading   = pick_cam();
        send_item(it);
        polls = $urandom_range(14, 1);
        while (polls > 0 && seq_ph != SEQ_IDLE) begin
            it = random_item();
            it.opcode        = OP_POLL;
            it.read_ok       = ($urandom_range(9) < 8);
            it.motor_running = ($urandom_range(9) < 7);
            it.left_reading  = pick_pawl(lim_left, 10);
            it.right_reading = pick_pawl(lim_right, 10);
            it.cam_reading   = pick_cam();
            send_item(it);
            polls--;
        end
    endtask

    task automatic run_items(input int n);
        int first;
        first = items_taken;
        while (items_taken - first < n) begin
            if ($urandom_range(9) == 0)
                send_item(random_item());
            else
                random_sequence();
        end
    endtask

    task automatic test_directed_cases();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_item(sensor_item(OP_POLL, MODE_LEFT, 1'b1, 16'd0, 16'sd0, 16'd0, 1'b0));
        send_item(sensor_item(OP_START, MODE_NONE, 1'b1, 16'hFFFF, 16'sd0, 16'hFFFF, 1'b1));
        send_item(sensor_item(OP_START, MODE_LEFT, 1'b0, 16'hFFFF, 16'sd0, 16'd0, 1'b1));
        send_item(sensor_item(OP_START, MODE_LEFT, 1'b1, 16'd0, 16'sd0, 16'hFFFF, 1'b0));
        send_item(sensor_item(OP_START, MODE_LEFT, 1'b1, 16'hFFFF, 16'sd0, 16'd0, 1'b1));
        // read retry pending: the motor flag of the next poll is ignored
        send_item(sensor_item(OP_POLL, MODE_REST, 1'b0, 16'd0, 16'sd0, 16'd0, 1'b1));
        send_item(sensor_item(OP_POLL, MODE_NONE, 1'b1, 16'd600, 16'sd0, 16'd0, 1'b0));
        send_item(sensor_item(OP_POLL, MODE_LEFT, 1'b1, 16'd513, 16'sd0, 16'd0, 1'b0));
        send_item(sensor_item(OP_POLL, MODE_LEFT, 1'b1, 16'd512, 16'sd0, 16'd0, 1'b1));
        send_item(sensor_item(OP_START, MODE_RIGHT, 1'b1, 16'd0, 16'sd0, 16'd513, 1'b1));
        // new start while busy
        send_item(sensor_item(OP_START, MODE_REST, 1'b1, 16'd0, 16'sh7FFF, 16'd0, 1'b1));
        send_item(sensor_item(OP_POLL, MODE_LEFT, 1'b1, 16'd0, 16'sh8000, 16'd0, 1'b1));
        // restart, reversal and back-off on one poll
        send_item(sensor_item(OP_POLL, MODE_LEFT, 1'b1, 16'd0, 16'sd50, 16'd0, 1'b0));
        send_item(sensor_item(OP_START, MODE_REST, 1'b1, 16'd0, 16'sd0, 16'd0, 1'b1));
        send_item(sensor_item(OP_START, MODE_REST, 1'b0, 16'd0, 16'sd500, 16'd0, 1'b1));
        send_item(sensor_item(OP_START, MODE_REST, 1'b1, 16'd0, 16'shFF9B, 16'd0, 1'b1));
        send_item(sensor_item(OP_POLL, MODE_REST, 1'b0, 16'd0, 16'sd0, 16'd0, 1'b1));
        send_item(sensor_item(OP_POLL, MODE_REST, 1'b1, 16'd0, 16'sd101, 16'd0, 1'b0));
        send_item(sensor_item(OP_POLL, MODE_REST, 1'b1, 16'd0, 16'shFF9C, 16'd0, 1'b1));
        send_item(sensor_item(OP_POLL, MODE_RIGHT, 1'b0, 16'hFFFF, 16'sh8000, 16'hFFFF, 1'b1));
    endtask

    task automatic test_retry_limits();
        wait_drained();
        set_config(16'd512, 16'd512, 16'sd100, -16'sd100, 16'sd0, 8'd0);
        send_item(sensor_item(OP_START, MODE_LEFT, 1'b1, 16'hFFFF, 16'sd0, 16'd0, 1'b1));
        send_item(sensor_item(OP_POLL, MODE_LEFT, 1'b1, 16'hFFFF, 16'sd0, 16'd0, 1'b0));
        send_item(sensor_item(OP_START, MODE_LEFT, 1'b1, 16'hFFFF, 16'sd0, 16'd0, 1'b1));
        send_item(sensor_item(OP_POLL, MODE_LEFT, 1'b1, 16'd0, 16'sd0, 16'd0, 1'b1));
        send_item(sensor_item(OP_START, MODE_REST, 1'b1, 16'd0, 16'sd5000, 16'd0, 1'b1));
        send_item(sensor_item(OP_POLL, MODE_REST, 1'b1, 16'd0, 16'sd0, 16'd0, 1'b1));
        wait_drained();
        set_config(16'd512, 16'd512, 16'sd100, -16'sd100, 16'sd0, 8'd1);
        send_item(sensor_item(OP_START, MODE_RIGHT, 1'b1, 16'd0, 16'sd0, 16'hFFFF, 1'b1));
        send_item(sensor_item(OP_POLL, MODE_RIGHT, 1'b0, 16'd0, 16'sd0, 16'hFFFF, 1'b0));
        send_item(sensor_item(OP_POLL, MODE_RIGHT, 1'b0, 16'd0, 16'sd0, 16'hFFFF, 1'b0));
        send_item(sensor_item(OP_START, MODE_REST, 1'b1, 16'd0, -16'sd5000, 16'd0, 1'b1));
        send_item(sensor_item(OP_POLL, MODE_REST, 1'b1, 16'd0, -16'sd4000, 16'd0, 1'b0));
        send_item(sensor_item(OP_POLL, MODE_REST, 1'b1, 16'd0, 16'sd0, 16'd0, 1'b0));
    endtask

    task automatic test_config_extremes();
        wait_drained();
        src_idle_pct   = 22;
        sink_stall_pct = 22;
        // empty cam window, middle at the top
        set_config(16'd0, 16'hFFFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 8'd255);
        run_items(30);
        wait_drained();
        // everything centered, middle at the bottom, no retries allowed
        set_config(16'hFFFF, 16'd0, 16'sh7FFF, 16'sh8000, 16'sh8000, 8'd0);
        run_items(30);
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n);
        int mid;
        int lo;
        int hi;
        int tmp;
        wait_drained();
        mid = int'($urandom_range(4000)) - 2000;
        lo  = mid - int'($urandom_range(1500));
        hi  = mid + int'($urandom_range(1500));
        if ($urandom_range(7) == 0) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        set_config(16'($urandom), 16'($urandom), hi[15:0], lo[15:0], mid[15:0],
                   ($urandom_range(5) == 0) ? 8'd255 : 8'($urandom_range(4)));
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        run_items(n);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_wdata  = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        reset_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_retry_limits();
        test_config_extremes();
        test_random_traffic(0, 0, 100);
        test_random_traffic(83, 0, 100);
        test_random_traffic(0, 83, 100);
        test_random_traffic(22, 22, 100);
        wait_drained();
        if (n_fail == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
